/* design/assert_macros.svh */
// Assertion helpers used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The condition must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

/* design/fse_pkg.sv */
package fse_pkg;

    localparam int FSE_FRAC_BITS = 14;
    localparam int COORD_W       = 16;
    localparam int OUT_W         = 20;
    localparam int NODE_W        = 4;
    localparam int ELEM_W        = 3;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic signed [OUT_W-1:0] OUT_HI = 20'sh7FFFF;
    localparam logic signed [OUT_W-1:0] OUT_LO = 20'sh80000;

    // Highest node index any element produces.
    localparam logic [NODE_W-1:0] MAX_NODE_IDX = 4'd9;

    // Hexahedron corner signs: a set bit means the factor is (1 - x).
    localparam logic [7:0] HEX_NEG_R = 8'b1001_1001;
    localparam logic [7:0] HEX_NEG_S = 8'b0011_0011;
    localparam logic [7:0] HEX_NEG_T = 8'b0000_1111;

    typedef enum logic [ELEM_W-1:0] {
        ELEM_TET4  = 3'd0,
        ELEM_TET10 = 3'd1,
        ELEM_HEX8  = 3'd2,
        ELEM_TRI3  = 3'd3,
        ELEM_TRI6  = 3'd4
    } t_elem;

    typedef struct packed {
        logic signed [COORD_W-1:0] coord_r;
        logic signed [COORD_W-1:0] coord_s;
        logic signed [COORD_W-1:0] coord_t;
    } t_in;

    typedef struct packed {
        logic [NODE_W-1:0]        node_index;
        logic signed [OUT_W-1:0]  shape_value;
        logic signed [OUT_W-1:0]  deriv_r;
        logic signed [OUT_W-1:0]  deriv_s;
        logic signed [OUT_W-1:0]  deriv_t;
        logic                     last_node;
    } t_out;

    // One classified point waiting for the node sequencer.
    typedef struct packed {
        t_elem             elem;
        logic [NODE_W-1:0] last_idx;
        t_in               coord;
    } t_job;

    // Index of the final node of an element type; zero for unused codes.
    function automatic logic [NODE_W-1:0] node_last_idx(input logic [ELEM_W-1:0] elem);
        logic [NODE_W-1:0] idx;
        case (elem)
            ELEM_TET4:  idx = 4'd3;
            ELEM_TET10: idx = 4'd9;
            ELEM_HEX8:  idx = 4'd7;
            ELEM_TRI3:  idx = 4'd2;
            ELEM_TRI6:  idx = 4'd5;
            default:    idx = 4'd0;
        endcase
        return idx;
    endfunction

    function automatic logic elem_supported(input logic [ELEM_W-1:0] elem);
        logic ok;
        case (elem)
            ELEM_TET4, ELEM_TET10, ELEM_HEX8, ELEM_TRI3, ELEM_TRI6: ok = 1'b1;
            default: ok = 1'b0;
        endcase
        return ok;
    endfunction

endpackage

/* design/fse_front.sv */
module fse_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [fse_pkg::ELEM_W-1:0]  i_cfg_wdata,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  fse_pkg::t_in                i_in_data,
    input  logic                        i_q_full,
    output logic                        o_push,
    output fse_pkg::t_job               o_job,
    output logic [fse_pkg::ELEM_W-1:0]  o_elem
);
    import fse_pkg::*;

    logic [ELEM_W-1:0] r_elem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elem <= ELEM_TET4;
        end else if (i_cfg_we) begin
            r_elem <= i_cfg_wdata;
        end
    end

    // Points for an unused element code are taken and dropped without results.
    assign o_in_ready     = !i_q_full;
    assign o_push         = i_in_valid && o_in_ready && elem_supported(r_elem);
    assign o_job.elem     = t_elem'(r_elem);
    assign o_job.last_idx = node_last_idx(r_elem);
    assign o_job.coord    = i_in_data;
    assign o_elem         = r_elem;

endmodule

/* design/fse_queue.sv */
module fse_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  fse_pkg::t_job  i_data,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output fse_pkg::t_job  o_data
);
    import fse_pkg::*;

    localparam int QA = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_job            r_mem [QUEUE_DEPTH];
    logic [QA-1:0]   r_wp;
    logic [QA-1:0]   r_rp;
    logic [CW-1:0]   r_cnt;
    logic            do_push;
    logic            do_pop;

    assign o_full  = (r_cnt == CW'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    function automatic logic [QA-1:0] wrap_inc(input logic [QA-1:0] p);
        return (p == QA'(QUEUE_DEPTH - 1)) ? '0 : p + QA'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= wrap_inc(r_wp);
            end
            if (do_pop) begin
                r_rp <= wrap_inc(r_rp);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

/* design/fse_back.sv */
module fse_back #(
    parameter int FRAC_BITS = fse_pkg::FSE_FRAC_BITS
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  fse_pkg::t_job  i_q_data,
    output logic           o_pop,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output fse_pkg::t_out  o_out_data
);
    import fse_pkg::*;

    localparam int M  = (FRAC_BITS > COORD_W - 1) ? FRAC_BITS : COORD_W - 1;
    localparam int AW = M + 6;
    localparam int PW = 2 * AW;
    localparam int QW = 2 * M + 4 - FRAC_BITS;
    localparam int DW = QW + AW;
    localparam int XW = ((PW > DW) ? PW : DW) + 2;

    localparam logic signed [AW-1:0] ONE_A  = AW'(64'sd1 <<< FRAC_BITS);
    localparam logic signed [XW-1:0] ONE_X  = XW'(1);
    localparam logic signed [XW-1:0] SAT_HI = XW'(OUT_HI);
    localparam logic signed [XW-1:0] SAT_LO = XW'(OUT_LO);
    localparam logic [5:0]           K_Q    = 6'(FRAC_BITS);
    localparam logic [5:0]           K_H    = 6'(FRAC_BITS + 3);

    typedef enum logic [1:0] {
        VM_LIN,
        VM_QUAD,
        VM_HEX
    } t_vmode;

    // floor(x / 2^k + 1/2)
    function automatic logic signed [XW-1:0] rnd_shift(input logic signed [XW-1:0] x,
                                                       input logic [5:0] k);
        return (x + (ONE_X <<< (k - 6'd1))) >>> k;
    endfunction

    function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [XW-1:0] x);
        logic signed [OUT_W-1:0] y;
        if (x > SAT_HI) begin
            y = OUT_HI;
        end else if (x < SAT_LO) begin
            y = OUT_LO;
        end else begin
            y = OUT_W'(x);
        end
        return y;
    endfunction

    // Node sequencer.
    logic              r_busy;
    t_job              r_job;
    logic [NODE_W-1:0] r_node;
    logic              adv;
    logic              job_done;
    logic              take_next;

    assign adv       = !o_out_valid || i_out_ready;
    assign job_done  = (r_node == r_job.last_idx);
    assign take_next = adv && (!r_busy || job_done);
    assign o_pop     = take_next && i_q_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_node <= '0;
        end else if (take_next) begin
            r_busy <= i_q_valid;
            r_node <= '0;
        end else if (adv && r_busy) begin
            r_node <= r_node + NODE_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_q_data;
        end
    end

    // Stage A: per-node selection of linear terms and multiplier operands.
    logic                  tri_el;
    logic signed [AW-1:0]  rr, ss, tt, ll;
    logic [NODE_W-1:0]     kq;
    t_vmode                a_mode;
    logic signed [AW-1:0]  a_v, a_dr, a_ds, a_dt, a_opa, a_opb, a_ft;
    logic                  a_nr, a_ns, a_nt;

    assign tri_el = (r_job.elem == ELEM_TRI3) || (r_job.elem == ELEM_TRI6);
    assign rr     = AW'(r_job.coord.coord_r);
    assign ss     = AW'(r_job.coord.coord_s);
    assign tt     = tri_el ? '0 : AW'(r_job.coord.coord_t);
    assign ll     = ONE_A - rr - ss - tt;
    // The quadratic triangle has no fourth corner, so its edges follow on.
    assign kq     = (r_job.elem == ELEM_TRI6 && r_node >= NODE_W'(3)) ?
                    r_node + NODE_W'(1) : r_node;

    always_comb begin
        a_mode = VM_LIN;
        a_v    = '0;
        a_dr   = '0;
        a_ds   = '0;
        a_dt   = '0;
        a_opa  = '0;
        a_opb  = '0;
        a_ft   = '0;
        a_nr   = HEX_NEG_R[r_node[2:0]];
        a_ns   = HEX_NEG_S[r_node[2:0]];
        a_nt   = HEX_NEG_T[r_node[2:0]];
        case (r_job.elem)
            ELEM_TET4, ELEM_TRI3: begin
                case (r_node)
                    4'd0: begin
                        a_v  = ll;
                        a_dr = -ONE_A;
                        a_ds = -ONE_A;
                        a_dt = -ONE_A;
                    end
                    4'd1: begin
                        a_v  = rr;
                        a_dr = ONE_A;
                    end
                    4'd2: begin
                        a_v  = ss;
                        a_ds = ONE_A;
                    end
                    4'd3: begin
                        a_v  = tt;
                        a_dt = ONE_A;
                    end
                    default: ;
                endcase
            end
            ELEM_TET10, ELEM_TRI6: begin
                a_mode = VM_QUAD;
                case (kq)
                    4'd0: begin
                        a_opa = ll;
                        a_opb = (ll <<< 1) - ONE_A;
                        a_dr  = -(ONE_A <<< 1) - ONE_A + (rr <<< 2) + ((ss + tt) <<< 2);
                        a_ds  = -(ONE_A <<< 1) - ONE_A + (ss <<< 2) + ((rr + tt) <<< 2);
                        a_dt  = -(ONE_A <<< 1) - ONE_A + (tt <<< 2) + ((rr + ss) <<< 2);
                    end
                    4'd1: begin
                        a_opa = rr;
                        a_opb = (rr <<< 1) - ONE_A;
                        a_dr  = (rr <<< 2) - ONE_A;
                    end
                    4'd2: begin
                        a_opa = ss;
                        a_opb = (ss <<< 1) - ONE_A;
                        a_ds  = (ss <<< 2) - ONE_A;
                    end
                    4'd3: begin
                        a_opa = tt;
                        a_opb = (tt <<< 1) - ONE_A;
                        a_dt  = (tt <<< 2) - ONE_A;
                    end
                    4'd4: begin
                        a_opa = ll;
                        a_opb = rr <<< 2;
                        a_dr  = (ONE_A <<< 2) - (rr <<< 3) - ((ss + tt) <<< 2);
                        a_ds  = -(rr <<< 2);
                        a_dt  = -(rr <<< 2);
                    end
                    4'd5: begin
                        a_opa = rr;
                        a_opb = ss <<< 2;
                        a_dr  = ss <<< 2;
                        a_ds  = rr <<< 2;
                    end
                    4'd6: begin
                        a_opa = ss;
                        a_opb = ll <<< 2;
                        a_dr  = -(ss <<< 2);
                        a_ds  = (ONE_A <<< 2) - (ss <<< 3) - ((rr + tt) <<< 2);
                        a_dt  = -(ss <<< 2);
                    end
                    4'd7: begin
                        a_opa = ll;
                        a_opb = tt <<< 2;
                        a_dr  = -(tt <<< 2);
                        a_ds  = -(tt <<< 2);
                        a_dt  = (ONE_A <<< 2) - (tt <<< 3) - ((rr + ss) <<< 2);
                    end
                    4'd8: begin
                        a_opa = rr;
                        a_opb = tt <<< 2;
                        a_dr  = tt <<< 2;
                        a_dt  = rr <<< 2;
                    end
                    4'd9: begin
                        a_opa = ss;
                        a_opb = tt <<< 2;
                        a_ds  = tt <<< 2;
                        a_dt  = ss <<< 2;
                    end
                    default: ;
                endcase
            end
            ELEM_HEX8: begin
                a_mode = VM_HEX;
                a_opa  = a_nr ? ONE_A - rr : ONE_A + rr;
                a_opb  = a_ns ? ONE_A - ss : ONE_A + ss;
                a_ft   = a_nt ? ONE_A - tt : ONE_A + tt;
            end
            default: ;
        endcase
        if (tri_el) begin
            a_dt = '0;
        end
    end

    logic                  r_a_valid;
    t_vmode                r_a_mode;
    logic [NODE_W-1:0]     r_a_idx;
    logic                  r_a_last;
    logic signed [AW-1:0]  r_a_v, r_a_dr, r_a_ds, r_a_dt, r_a_opa, r_a_opb, r_a_ft;
    logic                  r_a_nr, r_a_ns, r_a_nt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (adv) begin
            r_a_valid <= r_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a_mode <= a_mode;
            r_a_idx  <= r_node;
            r_a_last <= job_done;
            r_a_v    <= a_v;
            r_a_dr   <= a_dr;
            r_a_ds   <= a_ds;
            r_a_dt   <= a_dt;
            r_a_opa  <= a_opa;
            r_a_opb  <= a_opb;
            r_a_ft   <= a_ft;
            r_a_nr   <= a_nr;
            r_a_ns   <= a_ns;
            r_a_nt   <= a_nt;
        end
    end

    // Stage B: the three products. For the hexahedron they are fr*fs, fs*ft and fr*ft.
    logic                  r_b_valid;
    t_vmode                r_b_mode;
    logic [NODE_W-1:0]     r_b_idx;
    logic                  r_b_last;
    logic signed [AW-1:0]  r_b_v, r_b_dr, r_b_ds, r_b_dt, r_b_ft;
    logic signed [PW-1:0]  r_b_p1, r_b_p2, r_b_p3;
    logic                  r_b_nr, r_b_ns, r_b_nt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (adv) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_b_mode <= r_a_mode;
            r_b_idx  <= r_a_idx;
            r_b_last <= r_a_last;
            r_b_v    <= r_a_v;
            r_b_dr   <= r_a_dr;
            r_b_ds   <= r_a_ds;
            r_b_dt   <= r_a_dt;
            r_b_ft   <= r_a_ft;
            r_b_nr   <= r_a_nr;
            r_b_ns   <= r_a_ns;
            r_b_nt   <= r_a_nt;
            r_b_p1   <= PW'(r_a_opa) * PW'(r_a_opb);
            r_b_p2   <= PW'(r_a_opb) * PW'(r_a_ft);
            r_b_p3   <= PW'(r_a_opa) * PW'(r_a_ft);
        end
    end

    // Stage C: rounding and saturation of everything but the hexahedron value.
    logic signed [XW-1:0]    c_p1r;
    logic signed [OUT_W-1:0] c_v, c_dr, c_ds, c_dt;

    assign c_p1r = rnd_shift(XW'(r_b_p1), K_Q);

    always_comb begin
        if (r_b_mode == VM_HEX) begin
            c_v  = '0;
            c_dr = sat_out(rnd_shift(r_b_nr ? -XW'(r_b_p2) : XW'(r_b_p2), K_H));
            c_ds = sat_out(rnd_shift(r_b_ns ? -XW'(r_b_p3) : XW'(r_b_p3), K_H));
            c_dt = sat_out(rnd_shift(r_b_nt ? -XW'(r_b_p1) : XW'(r_b_p1), K_H));
        end else begin
            c_v  = (r_b_mode == VM_QUAD) ? sat_out(c_p1r) : sat_out(XW'(r_b_v));
            c_dr = sat_out(XW'(r_b_dr));
            c_ds = sat_out(XW'(r_b_ds));
            c_dt = sat_out(XW'(r_b_dt));
        end
    end

    logic                    r_c_valid;
    logic                    r_c_hex;
    logic [NODE_W-1:0]       r_c_idx;
    logic                    r_c_last;
    logic signed [OUT_W-1:0] r_c_v, r_c_dr, r_c_ds, r_c_dt;
    logic signed [QW-1:0]    r_c_q;
    logic signed [AW-1:0]    r_c_ft;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (adv) begin
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_c_hex  <= (r_b_mode == VM_HEX);
            r_c_idx  <= r_b_idx;
            r_c_last <= r_b_last;
            r_c_v    <= c_v;
            r_c_dr   <= c_dr;
            r_c_ds   <= c_ds;
            r_c_dt   <= c_dt;
            r_c_q    <= QW'(c_p1r);
            r_c_ft   <= r_b_ft;
        end
    end

    // Stage D: second hexahedron product q*ft.
    logic                    r_d_valid;
    logic                    r_d_hex;
    logic [NODE_W-1:0]       r_d_idx;
    logic                    r_d_last;
    logic signed [OUT_W-1:0] r_d_v, r_d_dr, r_d_ds, r_d_dt;
    logic signed [DW-1:0]    r_d_p4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
        end else if (adv) begin
            r_d_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_d_hex  <= r_c_hex;
            r_d_idx  <= r_c_idx;
            r_d_last <= r_c_last;
            r_d_v    <= r_c_v;
            r_d_dr   <= r_c_dr;
            r_d_ds   <= r_c_ds;
            r_d_dt   <= r_c_dt;
            r_d_p4   <= DW'(r_c_q) * DW'(r_c_ft);
        end
    end

    // Output register.
    logic r_o_valid;
    t_out r_o_data;
    t_out n_o_data;

    always_comb begin
        n_o_data.node_index  = r_d_idx;
        n_o_data.shape_value = r_d_hex ? sat_out(rnd_shift(XW'(r_d_p4), K_H)) : r_d_v;
        n_o_data.deriv_r     = r_d_dr;
        n_o_data.deriv_s     = r_d_ds;
        n_o_data.deriv_t     = r_d_dt;
        n_o_data.last_node   = r_d_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (adv) begin
            r_o_valid <= r_d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_o_data <= n_o_data;
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_out_data  = r_o_data;

endmodule

/* design/fem_shape_function_evaluator.sv */
// Channel   Direction  Handshake                    Payload
// in        input      i_in_valid / o_in_ready      i_in_data  (t_in: coord_r, coord_s, coord_t)
// out       output     o_out_valid / i_out_ready    o_out_data (t_out: one node result)
// cfg       input      i_cfg_we, no wait            i_cfg_wdata (element_type)
//
// One node result leaves per cycle while the output is not stalled and points are
// queued: a point yields 4 results for tet4, 10 for tet10, 8 for hex8, 3 for tri3
// and 6 for tri6, set by the node sequencer in the back end. A point with an unused
// element code is taken and yields no result.
// Reset is synchronous and active low; it empties the queue and the pipeline and
// selects tet4. A stall on the output freezes the whole back pipeline, while the
// front keeps taking points until the two-entry queue fills.
`include "assert_macros.svh"

module fem_shape_function_evaluator #(
    parameter int FRAC_BITS = fse_pkg::FSE_FRAC_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [fse_pkg::ELEM_W-1:0]  i_cfg_wdata,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  fse_pkg::t_in                i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output fse_pkg::t_out               o_out_data
);
    import fse_pkg::*;

    // Front to queue.
    logic              q_push;
    logic              q_full;
    t_job              q_wdata;
    logic [ELEM_W-1:0] elem;

    // Queue to back.
    logic q_valid;
    logic q_pop;
    t_job q_rdata;

    // The front holds the element type register and classifies each input
    // transaction; supported points enter the queue with their final node index.
    fse_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_job       (q_wdata),
        .o_elem      (elem)
    );

    // A short queue decouples point intake from node sequencing.
    fse_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_rdata)
    );

    // The back end walks the nodes of each point through a pipeline of
    // selection, products, rounding, the second hexahedron product and the
    // output register.
    fse_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_data    (q_rdata),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // The front must never push into a full queue.
    `ASSERT_NEVER(a_no_overflow, i_clk, i_rst_n, q_push && q_full, "queue overflow")

    // The last result of a point carries the final node of the selected element.
    `ASSERT_IMP(a_last_idx, i_clk, i_rst_n, o_out_valid && o_out_data.last_node, o_out_data.node_index == node_last_idx(elem), "last node index mismatch")

    // Triangle results never carry a t derivative.
    `ASSERT_IMP(a_tri_dt, i_clk, i_rst_n, o_out_valid && (elem == ELEM_TRI3 || elem == ELEM_TRI6), o_out_data.deriv_t == '0, "nonzero t derivative on triangle")

endmodule
